### hw/rtl/mbrs_pkg.sv
// Shared constants, codes and the CRC-16 byte step for the Modbus RTU slave.
`timescale 1ns / 1ps
`default_nettype none
package mbrs_pkg;

    localparam int FRAME_LEN   = 8;
    localparam int WORD_ADDR_W = 17;

    // Input item kinds carried on the slave-side tuser.
    localparam logic [1:0] MODE_BYTE  = 2'd0;
    localparam logic [1:0] MODE_LOCAL = 2'd1;
    localparam logic [1:0] MODE_RESET = 2'd2;

    // Result kinds carried on the master-side tuser.
    localparam logic KIND_BYTES  = 1'b0;
    localparam logic KIND_NOTICE = 1'b1;

    // Modbus function and exception codes.
    localparam logic [7:0] FUNC_READ_HOLD  = 8'd3;
    localparam logic [7:0] FUNC_READ_INPUT = 8'd4;
    localparam logic [7:0] FUNC_WRITE_ONE  = 8'd6;
    localparam logic [7:0] EXC_BIT         = 8'h80;
    localparam logic [7:0] EXC_ILLEGAL_FN  = 8'd1;
    localparam logic [7:0] EXC_ILLEGAL_VAL = 8'd3;

    // Kinds of response body.
    localparam logic [1:0] RSP_EXC  = 2'd0;
    localparam logic [1:0] RSP_READ = 2'd1;
    localparam logic [1:0] RSP_ECHO = 2'd2;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // One byte through the reflected CRC-16, eight shift steps.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int b = 0; b < 8; b++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/mbrs_bank.sv
// Register bank memory with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module mbrs_bank #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic                               clk,
    input  wire logic                               we,
    input  wire logic [AW-1:0]                      waddr,
    input  wire logic [15:0]                        wdata,
    input  wire logic                               re,
    input  wire logic [mbrs_pkg::WORD_ADDR_W-1:0]   raddr,
    output logic      [15:0]                        rdata
);

    logic [15:0] mem [0:DEPTH-1];
    logic [15:0] rd_q_reg;
    logic        oob_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // Read port; addresses beyond the bank read as zero.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_q_reg <= mem[raddr[AW-1:0]];
            oob_reg  <= (32'(raddr) >= DEPTH);
        end
    end

    assign rdata = oob_reg ? 16'h0000 : rd_q_reg;

endmodule
`default_nettype wire

### hw/rtl/modbus_rtu_slave_frame_handler.sv
// Modbus RTU slave: frame capture, CRC check, request handling and response packing.
//
// Input items arrive on the s_ stream: tuser gives the mode (received byte, local
// register write, frame reset). Result items leave on the m_ stream: tuser says
// whether the item is response bytes or a register write notice, tlast marks the
// final result of a request. device_address is written through the APB port.
// Bytes, local writes and frame resets are taken while idle. The eighth byte of a
// frame starts a sequencer around one shared CRC byte unit: it checks the frame CRC
// and, if it matches, emits the response, CRC bytes included, and flushes the last
// group, so a 125-word read (255 bytes) keeps s_tready low until the flush; the pace
// is set by the byte-per-cycle CRC unit, when the output does not stall, and by the
// single bank read port. A write request also passes through a notice state before
// its echo. A stalled receiver holds the output register and the sequencer waits
// with its packer full; nothing is lost. After reset a clearing pass zeroes every
// word of the register bank with s_tready low; configuration writes are taken during it.
`timescale 1ns / 1ps
`default_nettype none
module modbus_rtu_slave_frame_handler #(
    parameter int BANK_DEPTH     = 256,
    parameter int MAX_READ_WORDS = 125
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // rx_byte[7:0], local_addr[15:8], local_value[31:16]
    input  wire logic [1:0]  s_tuser,   // mode[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [71:0] m_tdata,   // tx_data[31:0], tx_count[34:32], notice_addr[50:35],
                                        // notice_value[66:51], zero fill[71:67]
    output logic             m_tuser,   // kind[0]
    output logic             m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int AW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int WAW = mbrs_pkg::WORD_ADDR_W;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_CHECK  = 3'd2;
    localparam logic [2:0] ST_NOTICE = 3'd3;
    localparam logic [2:0] ST_GEN    = 3'd4;
    localparam logic [2:0] ST_CRCLO  = 3'd5;
    localparam logic [2:0] ST_CRCHI  = 3'd6;
    localparam logic [2:0] ST_FLUSH  = 3'd7;

    localparam logic [2:0] REG_DEV_ADDR = 3'd0;

    logic [2:0]     state_reg, state_next;
    logic [7:0]     dev_addr_reg;
    logic           receiving_reg, receiving_next;
    logic [2:0]     fill_reg, fill_next;
    logic [7:0]     fb_reg [0:mbrs_pkg::FRAME_LEN-1];
    logic [7:0]     fb_next [0:mbrs_pkg::FRAME_LEN-1];
    logic [AW-1:0]  clr_reg, clr_next;
    logic [15:0]    crc_reg, crc_next;
    logic [7:0]     bi_reg, bi_next;
    logic [7:0]     len_m1_reg, len_m1_next;
    logic [1:0]     rsp_reg, rsp_next;
    logic [7:0]     code_reg, code_next;
    logic [WAW-1:0] word_addr_reg, word_addr_next;
    logic [31:0]    pack_data_reg, pack_data_next;
    logic [2:0]     pack_cnt_reg, pack_cnt_next;

    logic           out_valid_reg, out_valid_next;
    logic           out_kind_reg, out_kind_next;
    logic [31:0]    out_data_reg, out_data_next;
    logic [2:0]     out_cnt_reg, out_cnt_next;
    logic [15:0]    out_naddr_reg, out_naddr_next;
    logic [15:0]    out_nval_reg, out_nval_next;
    logic           out_last_reg, out_last_next;

    logic           bank_we;
    logic [AW-1:0]  bank_waddr;
    logic [15:0]    bank_wdata;
    logic           bank_re;
    logic [WAW-1:0] bank_raddr;
    logic [15:0]    bank_rdata;

    logic [1:0]     in_mode;
    logic [7:0]     in_rx;
    logic [7:0]     in_laddr;
    logic [15:0]    in_lval;
    logic [7:0]     func;
    logic [15:0]    first_w;
    logic [15:0]    second_w;
    logic           out_free;
    logic           emit;
    logic [7:0]     emit_byte;
    logic [7:0]     gen_byte;
    logic [1:0]     base;
    logic           cfg_wr;

    assign in_mode  = s_tuser;
    assign in_rx    = s_tdata[7:0];
    assign in_laddr = s_tdata[15:8];
    assign in_lval  = s_tdata[31:16];
    assign func     = fb_reg[1];
    assign first_w  = {fb_reg[2], fb_reg[3]};
    assign second_w = {fb_reg[4], fb_reg[5]};
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_DEV_ADDR[2]);
    assign prdata = (paddr[2] == REG_DEV_ADDR[2]) ? {24'h000000, dev_addr_reg} : 32'h0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dev_addr_reg <= 8'd1;
        else if (cfg_wr)
            dev_addr_reg <= pwdata[7:0];
    end

    // Response body byte at the current index; an echo repeats the request as received.
    always_comb
    begin
        if (bi_reg == 8'd0)
            gen_byte = (rsp_reg == mbrs_pkg::RSP_ECHO) ? fb_reg[0] : dev_addr_reg;
        else if (bi_reg == 8'd1)
            gen_byte = (rsp_reg == mbrs_pkg::RSP_EXC) ? (func | mbrs_pkg::EXC_BIT) : func;
        else if (bi_reg == 8'd2)
        begin
            case (rsp_reg)
                mbrs_pkg::RSP_EXC:  gen_byte = code_reg;
                mbrs_pkg::RSP_READ: gen_byte = {second_w[6:0], 1'b0};
                default:            gen_byte = fb_reg[2];
            endcase
        end
        else if (rsp_reg == mbrs_pkg::RSP_READ)
            gen_byte = bi_reg[0] ? bank_rdata[15:8] : bank_rdata[7:0];
        else
            gen_byte = fb_reg[bi_reg[2:0]];
    end

    // Sequencer, shared CRC unit and response packer.
    always_comb
    begin
        state_next     = state_reg;
        receiving_next = receiving_reg;
        fill_next      = fill_reg;
        fb_next        = fb_reg;
        clr_next       = clr_reg;
        crc_next       = crc_reg;
        bi_next        = bi_reg;
        len_m1_next    = len_m1_reg;
        rsp_next       = rsp_reg;
        code_next      = code_reg;
        word_addr_next = word_addr_reg;
        pack_data_next = pack_data_reg;
        pack_cnt_next  = pack_cnt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_kind_next  = out_kind_reg;
        out_data_next  = out_data_reg;
        out_cnt_next   = out_cnt_reg;
        out_naddr_next = out_naddr_reg;
        out_nval_next  = out_nval_reg;
        out_last_next  = out_last_reg;
        bank_we        = 1'b0;
        bank_waddr     = clr_reg;
        bank_wdata     = 16'h0000;
        bank_re        = 1'b0;
        bank_raddr     = word_addr_reg;
        emit           = 1'b0;
        emit_byte      = gen_byte;
        base           = pack_cnt_reg[1:0];

        case (state_reg)
            ST_CLEAR:
            begin
                bank_we  = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(BANK_DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (in_mode)
                        mbrs_pkg::MODE_LOCAL:
                        begin
                            if (32'(in_laddr) < BANK_DEPTH)
                            begin
                                bank_we    = 1'b1;
                                bank_waddr = AW'(in_laddr);
                                bank_wdata = in_lval;
                            end
                        end
                        mbrs_pkg::MODE_RESET:
                        begin
                            receiving_next = 1'b0;
                            fill_next      = 3'd0;
                        end
                        mbrs_pkg::MODE_BYTE:
                        begin
                            if (!receiving_reg)
                            begin
                                if (in_rx == dev_addr_reg)
                                begin
                                    receiving_next = 1'b1;
                                    fb_next[0]     = in_rx;
                                    fill_next      = 3'd1;
                                end
                            end
                            else
                            begin
                                fb_next[fill_reg] = in_rx;
                                fill_next         = fill_reg + 1'b1;
                                if (fill_reg == 3'(mbrs_pkg::FRAME_LEN - 1))
                                begin
                                    receiving_next = 1'b0;
                                    fill_next      = 3'd0;
                                    crc_next       = mbrs_pkg::CRC_INIT;
                                    bi_next        = 8'd0;
                                    state_next     = ST_CHECK;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_CHECK:
            begin
                if (bi_reg != 8'd6)
                begin
                    crc_next = mbrs_pkg::crc16_byte(crc_reg, fb_reg[bi_reg[2:0]]);
                    bi_next  = bi_reg + 1'b1;
                end
                else if (crc_reg == {fb_reg[7], fb_reg[6]})
                begin
                    crc_next       = mbrs_pkg::CRC_INIT;
                    bi_next        = 8'd0;
                    bank_re        = 1'b1;
                    bank_raddr     = WAW'(first_w);
                    word_addr_next = WAW'(first_w) + 1'b1;
                    state_next     = ST_GEN;
                    if (func == mbrs_pkg::FUNC_READ_HOLD || func == mbrs_pkg::FUNC_READ_INPUT)
                    begin
                        if (second_w == 16'd0 || second_w > 16'(MAX_READ_WORDS))
                        begin
                            rsp_next    = mbrs_pkg::RSP_EXC;
                            code_next   = mbrs_pkg::EXC_ILLEGAL_VAL;
                            len_m1_next = 8'd2;
                        end
                        else
                        begin
                            rsp_next    = mbrs_pkg::RSP_READ;
                            len_m1_next = {second_w[6:0], 1'b0} + 8'd2;
                        end
                    end
                    else if (func == mbrs_pkg::FUNC_WRITE_ONE)
                    begin
                        rsp_next    = mbrs_pkg::RSP_ECHO;
                        len_m1_next = 8'd5;
                        state_next  = ST_NOTICE;
                    end
                    else
                    begin
                        rsp_next    = mbrs_pkg::RSP_EXC;
                        code_next   = mbrs_pkg::EXC_ILLEGAL_FN;
                        len_m1_next = 8'd2;
                    end
                end
                else
                    state_next = ST_IDLE;
            end
            ST_NOTICE:
            begin
                // The packer is empty here, so the notice only waits for the output register to be free.
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = mbrs_pkg::KIND_NOTICE;
                    out_data_next  = 32'h0;
                    out_cnt_next   = 3'd0;
                    out_naddr_next = first_w;
                    out_nval_next  = second_w;
                    out_last_next  = 1'b0;
                    if (32'(first_w) < BANK_DEPTH)
                    begin
                        bank_we    = 1'b1;
                        bank_waddr = AW'(first_w);
                        bank_wdata = second_w;
                    end
                    state_next = ST_GEN;
                end
            end
            ST_GEN:
            begin
                if (!pack_cnt_reg[2] || out_free)
                begin
                    emit     = 1'b1;
                    crc_next = mbrs_pkg::crc16_byte(crc_reg, gen_byte);
                    bi_next  = bi_reg + 1'b1;
                    // Fetch the next word as the low byte of this one leaves.
                    if (rsp_reg == mbrs_pkg::RSP_READ && bi_reg > 8'd2 && !bi_reg[0])
                    begin
                        bank_re        = 1'b1;
                        word_addr_next = word_addr_reg + 1'b1;
                    end
                    if (bi_reg == len_m1_reg)
                        state_next = ST_CRCLO;
                end
            end
            ST_CRCLO:
            begin
                if (!pack_cnt_reg[2] || out_free)
                begin
                    emit       = 1'b1;
                    emit_byte  = crc_reg[7:0];
                    state_next = ST_CRCHI;
                end
            end
            ST_CRCHI:
            begin
                if (!pack_cnt_reg[2] || out_free)
                begin
                    emit       = 1'b1;
                    emit_byte  = crc_reg[15:8];
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Packer: hand four full bytes, or the final group, to the output register.
        if ((pack_cnt_reg[2] || state_reg == ST_FLUSH) && out_free && pack_cnt_reg != 3'd0)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = mbrs_pkg::KIND_BYTES;
            out_data_next  = pack_data_reg;
            out_cnt_next   = pack_cnt_reg;
            out_naddr_next = 16'h0000;
            out_nval_next  = 16'h0000;
            out_last_next  = (state_reg == ST_FLUSH);
            pack_cnt_next  = 3'd0;
            base           = 2'd0;
        end
        if (emit)
        begin
            if (base == 2'd0)
                pack_data_next = {24'h000000, emit_byte};
            else
                pack_data_next[8*base +: 8] = emit_byte;
            pack_cnt_next = {1'b0, base} + 3'd1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            receiving_reg <= 1'b0;
            fill_reg      <= 3'd0;
            clr_reg       <= '0;
            pack_cnt_reg  <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            receiving_reg <= receiving_next;
            fill_reg      <= fill_next;
            clr_reg       <= clr_next;
            pack_cnt_reg  <= pack_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        fb_reg        <= fb_next;
        crc_reg       <= crc_next;
        bi_reg        <= bi_next;
        len_m1_reg    <= len_m1_next;
        rsp_reg       <= rsp_next;
        code_reg      <= code_next;
        word_addr_reg <= word_addr_next;
        pack_data_reg <= pack_data_next;
        out_kind_reg  <= out_kind_next;
        out_data_reg  <= out_data_next;
        out_cnt_reg   <= out_cnt_next;
        out_naddr_reg <= out_naddr_next;
        out_nval_reg  <= out_nval_next;
        out_last_reg  <= out_last_next;
    end

    mbrs_bank #(
        .DEPTH (BANK_DEPTH),
        .AW    (AW)
    ) u_bank (
        .clk   (clk),
        .we    (bank_we),
        .waddr (bank_waddr),
        .wdata (bank_wdata),
        .re    (bank_re),
        .raddr (bank_raddr),
        .rdata (bank_rdata)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b00000, out_nval_reg, out_naddr_reg, out_cnt_reg, out_data_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule
`default_nettype wire

### hw/rtl/mbrs_checker.sv
// Port-level checks for the Modbus RTU slave, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module mbrs_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [71:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast
);

    // A stalled result keeps its valid.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // A write notice is never marked last, since its echo follows it.
    a_notice_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> !m_tlast)
        else $error("write notice marked last");

    // Byte results carry one to four bytes and no notice fields.
    a_byte_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[34:32] != 3'd0 && m_tdata[34:32] <= 3'd4
                                 && m_tdata[66:35] == 32'h0)
        else $error("bad byte result");

    // Notices carry no response bytes.
    a_notice_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[34:0] == 35'h0)
        else $error("notice carries bytes");

endmodule

bind modbus_rtu_slave_frame_handler mbrs_checker u_mbrs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire
